// ===== rtl/bole_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bole_pkg: shared types and constants of the bounded ordered list engine
// Op and status codes, payload structs and size constants.
// ----------------------------------------------------------------------------
package bole_pkg;

  localparam int unsigned Capacity   = 16;
  localparam int unsigned MaxResults = 16;
  localparam int unsigned PosW       = 5;
  localparam int unsigned CountW     = 5;

  typedef enum logic [3:0] {
    OP_INS_FRONT = 4'd0,
    OP_INS_BACK  = 4'd1,
    OP_INS_AT    = 4'd2,
    OP_DEL_FRONT = 4'd3,
    OP_DEL_BACK  = 4'd4,
    OP_DEL_AT    = 4'd5,
    OP_SORT      = 4'd6,
    OP_SEARCH    = 4'd7,
    OP_DISPLAY   = 4'd8
  } op_e;

  typedef enum logic [2:0] {
    ST_OK       = 3'd0,
    ST_INVALID  = 3'd1,
    ST_RANGE    = 3'd2,
    ST_EMPTY    = 3'd3,
    ST_FULL     = 3'd4,
    ST_NOTFOUND = 3'd5
  } status_e;

  typedef struct packed {
    logic [3:0]         op;
    logic signed [31:0] value_in;
    logic [7:0]         position_in;
  } req_t;

  typedef struct packed {
    logic [2:0]         status;
    logic signed [31:0] value_out;
    logic [PosW-1:0]    position_out;
    logic [CountW-1:0]  count_out;
    logic               last;
  } rsp_t;

endpackage

// ===== rtl/bole_store.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bole_store: element memory
// One write port and one read port, read data registered.
// ----------------------------------------------------------------------------
module bole_store #(
  parameter int unsigned Capacity = bole_pkg::Capacity,
  localparam int unsigned AddrW   = $clog2(Capacity)
) (
  input  logic             clk_i,
  input  logic             rd_en_i,
  input  logic [AddrW-1:0] rd_addr_i,
  input  logic             wr_en_i,
  input  logic [AddrW-1:0] wr_addr_i,
  input  logic [31:0]      wr_data_i,
  output logic [31:0]      rd_data_o
);

  logic [31:0] mem_q [Capacity];

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem_q[wr_addr_i] <= wr_data_i;
    end
    if (rd_en_i) begin
      rd_data_o <= mem_q[rd_addr_i];
    end
  end

endmodule

// ===== rtl/bounded_ordered_list_engine.sv =====
`timescale 1ns / 1ps
// Sequencing: error, unused and short-sort ops go straight to the response state;
//   insert/delete read then write per element moved; search ends at a match or the list end;
//   display gives one element per cycle; sort runs shrinking passes until no swap or two remain.
// Throughput: one command at a time; busy is high from the transfer until the last result shows.
// Reset: rst_ni clears count and control; list memory contents are undefined until written.
// Results cannot be stalled: each is shown for one cycle with done_o high.
// ----------------------------------------------------------------------------
// bounded_ordered_list_engine: ordered list of signed values in one RAM
// A sequencer shifts, sorts, searches and displays through a single memory.
// ----------------------------------------------------------------------------
module bounded_ordered_list_engine #(
  parameter int unsigned Capacity = bole_pkg::Capacity
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            start,
  output logic            busy,
  input  bole_pkg::req_t  req_i,
  output logic            done_o,
  output bole_pkg::rsp_t  rsp_o
);

  localparam int unsigned AddrW = $clog2(Capacity);
  localparam int unsigned CntW  = $clog2(Capacity + 1);

  typedef enum logic [3:0] {
    S_IDLE, S_SHIFT_RD, S_SHIFT_WR, S_SORT_LD, S_SORT_FIRST, S_SORT_CMP, S_SORT_TAIL,
    S_SEARCH, S_DISP, S_RESP
  } state_e;

  state_e             state_q;
  logic [CntW-1:0]    count_q;
  logic [CntW-1:0]    idx_q;
  logic [CntW-1:0]    stop_q;
  logic [CntW-1:0]    end_q;
  logic               swapped_q;
  logic               ins_q;
  logic signed [31:0] val_q;
  logic signed [31:0] a_q;
  logic [2:0]         st_q;
  logic [4:0]         pos_q;
  logic               disp_v_q;
  logic               srch_v_q;
  logic               rd_en, wr_en;
  logic [AddrW-1:0]   rd_addr, wr_addr;
  logic [31:0]        wr_data, rd_data;
  logic [CntW-1:0]    disp_n;
  logic [CntW:0]      pos_ext;
  logic               sort_gt;

  bole_store #(.Capacity(Capacity)) u_store (
    .clk_i, .rd_en_i(rd_en), .rd_addr_i(rd_addr), .wr_en_i(wr_en),
    .wr_addr_i(wr_addr), .wr_data_i(wr_data), .rd_data_o(rd_data)
  );

  assign busy    = (state_q != S_IDLE);
  assign pos_ext = (CntW+1)'(req_i.position_in > 8'(Capacity) ? 8'(Capacity + 1)
                                                             : req_i.position_in);
  assign disp_n  = (count_q > CntW'(bole_pkg::MaxResults)) ? CntW'(bole_pkg::MaxResults)
                                                          : count_q;
  assign sort_gt = ($signed(a_q) > $signed(rd_data));

  // memory port control
  always_comb begin
    rd_en   = 1'b0;
    rd_addr = '0;
    wr_en   = 1'b0;
    wr_addr = '0;
    wr_data = val_q;
    case (state_q)
      S_SHIFT_RD: begin
        rd_en   = (idx_q != stop_q);
        rd_addr = ins_q ? AddrW'(idx_q - 1'b1) : AddrW'(idx_q + 1'b1);
        wr_en   = (idx_q == stop_q) && ins_q;
        wr_addr = AddrW'(idx_q);
      end
      S_SHIFT_WR: begin
        wr_en   = 1'b1;
        wr_addr = AddrW'(idx_q);
        wr_data = rd_data;
      end
      S_SORT_LD: begin
        rd_en = 1'b1; rd_addr = '0;
      end
      S_SORT_FIRST: begin
        rd_en = 1'b1; rd_addr = AddrW'(idx_q + 1'b1);
      end
      S_SORT_CMP: begin
        // drop the smaller value at idx, carry the larger one forward in a_q
        wr_en   = 1'b1;
        wr_addr = AddrW'(idx_q);
        wr_data = sort_gt ? rd_data : a_q;
        rd_en   = (idx_q + 2'd2 < end_q);
        rd_addr = AddrW'(idx_q + 2'd2);
      end
      S_SORT_TAIL: begin
        wr_en   = 1'b1;
        wr_addr = AddrW'(idx_q + 1'b1);
        wr_data = a_q;
      end
      S_SEARCH, S_DISP: begin
        rd_en = (idx_q < count_q); rd_addr = AddrW'(idx_q);
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE; count_q <= '0; done_o <= 1'b0; rsp_o <= '0;
      disp_v_q <= 1'b0; srch_v_q <= 1'b0;
    end else begin
      done_o <= 1'b0;
      case (state_q)
        S_IDLE: if (start) begin
          val_q <= req_i.value_in; st_q <= bole_pkg::ST_OK; pos_q <= '0;
          state_q <= S_RESP;
          case (req_i.op)
            bole_pkg::OP_INS_FRONT, bole_pkg::OP_INS_BACK, bole_pkg::OP_INS_AT: begin
              if (req_i.op == bole_pkg::OP_INS_AT && req_i.position_in == 8'd0)
                st_q <= bole_pkg::ST_INVALID;
              else if (count_q >= CntW'(Capacity)) st_q <= bole_pkg::ST_FULL;
              else if (req_i.op == bole_pkg::OP_INS_AT &&
                       pos_ext > {1'b0, count_q} + 1'b1) st_q <= bole_pkg::ST_RANGE;
              else begin
                ins_q <= 1'b1; idx_q <= count_q; state_q <= S_SHIFT_RD;
                stop_q <= (req_i.op == bole_pkg::OP_INS_FRONT) ? '0 :
                          (req_i.op == bole_pkg::OP_INS_BACK) ? count_q :
                          CntW'(pos_ext - 1'b1);
              end
            end
            bole_pkg::OP_DEL_FRONT, bole_pkg::OP_DEL_BACK, bole_pkg::OP_DEL_AT: begin
              if (req_i.op == bole_pkg::OP_DEL_AT && req_i.position_in == 8'd0)
                st_q <= bole_pkg::ST_INVALID;
              else if (count_q == '0) st_q <= bole_pkg::ST_EMPTY;
              else if (req_i.op == bole_pkg::OP_DEL_AT && pos_ext > {1'b0, count_q})
                st_q <= bole_pkg::ST_RANGE;
              else begin
                ins_q <= 1'b0; state_q <= S_SHIFT_RD; stop_q <= count_q - 1'b1;
                idx_q <= (req_i.op == bole_pkg::OP_DEL_FRONT) ? '0 :
                         (req_i.op == bole_pkg::OP_DEL_BACK) ? count_q - 1'b1 :
                         CntW'(pos_ext - 1'b1);
              end
            end
            bole_pkg::OP_SORT: if (count_q > CntW'(1)) begin
              end_q <= count_q; idx_q <= '0; swapped_q <= 1'b0; state_q <= S_SORT_LD;
            end
            bole_pkg::OP_SEARCH: begin
              idx_q <= '0; srch_v_q <= 1'b0; state_q <= S_SEARCH;
            end
            bole_pkg::OP_DISPLAY: begin
              if (count_q == '0) st_q <= bole_pkg::ST_EMPTY;
              else begin idx_q <= '0; disp_v_q <= 1'b0; state_q <= S_DISP; end
            end
            default: ;
          endcase
        end
        S_SHIFT_RD: begin
          if (idx_q == stop_q) begin
            count_q <= ins_q ? count_q + 1'b1 : count_q - 1'b1;
            state_q <= S_RESP;
          end else state_q <= S_SHIFT_WR;
        end
        S_SHIFT_WR: begin
          idx_q   <= ins_q ? idx_q - 1'b1 : idx_q + 1'b1;
          state_q <= S_SHIFT_RD;
        end
        S_SORT_LD: state_q <= S_SORT_FIRST;
        S_SORT_FIRST: begin a_q <= rd_data; state_q <= S_SORT_CMP; end
        S_SORT_CMP: begin
          if (sort_gt) swapped_q <= 1'b1;
          else a_q <= rd_data;
          if (idx_q + 2'd2 < end_q) idx_q <= idx_q + 1'b1;
          else state_q <= S_SORT_TAIL;
        end
        S_SORT_TAIL: begin
          if (swapped_q && end_q > CntW'(2)) begin
            end_q <= end_q - 1'b1; idx_q <= '0; swapped_q <= 1'b0;
            state_q <= S_SORT_LD;
          end else state_q <= S_RESP;
        end
        S_SEARCH: begin
          srch_v_q <= (idx_q < count_q);
          if (srch_v_q && rd_data == val_q) begin
            pos_q <= 5'(idx_q); state_q <= S_RESP;
          end else if (idx_q >= count_q) begin
            st_q <= bole_pkg::ST_NOTFOUND; state_q <= S_RESP;
          end else idx_q <= idx_q + 1'b1;
        end
        S_DISP: begin
          disp_v_q <= 1'b1;
          if (disp_v_q) begin
            done_o <= 1'b1;
            rsp_o.status <= bole_pkg::ST_OK; rsp_o.value_out <= rd_data;
            rsp_o.position_out <= 5'(idx_q); rsp_o.count_out <= 5'(count_q);
            rsp_o.last <= (idx_q == disp_n);
            if (idx_q == disp_n) state_q <= S_IDLE;
          end
          idx_q <= idx_q + 1'b1;
        end
        S_RESP: begin
          done_o <= 1'b1;
          rsp_o.status <= st_q; rsp_o.value_out <= '0; rsp_o.position_out <= pos_q;
          rsp_o.count_out <= 5'(count_q); rsp_o.last <= 1'b1;
          state_q <= S_IDLE;
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CntW'(Capacity));
  a_busy_after_transfer: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy) |=> busy);
  a_last_frees: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> (rsp_o.last == !busy));
  a_status_legal: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> (rsp_o.status <= bole_pkg::ST_NOTFOUND));

endmodule
